[hw/rtl/double_knock_detector_top_assert.svh]
// Assertion macros for the double-knock detector.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef DOUBLE_KNOCK_DETECTOR_TOP_ASSERT_SVH
`define DOUBLE_KNOCK_DETECTOR_TOP_ASSERT_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define DKD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("double_knock_detector: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define DKD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("double_knock_detector: next-cycle check failed");
`else
`define DKD_ASSERT_SAME(lbl, ante, cons)
`define DKD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/dkd_pkg.sv]
package dkd_pkg;

  // Field widths of the configuration registers.
  localparam int WIN_LEN_W = 8;
  localparam int GAP_W     = 16;
  localparam int ELAPSED_W = 8;

  // Reset values of the configuration registers.
  localparam logic [WIN_LEN_W-1:0] RESET_WINDOW_LEN = 8'd100;
  localparam logic [GAP_W-1:0]     RESET_KNOCK_GAP  = 16'd2000;

  // Configuration as seen by the detector core.
  typedef struct packed {
    logic [WIN_LEN_W-1:0] window_len;
    logic [GAP_W-1:0]     knock_gap_ms;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic calibrated;
    logic window_done;
    logic vibration;
    logic knock;
  } result_t;

endpackage

[hw/rtl/dkd_cfg.sv]
module dkd_cfg
  import dkd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  // Registers sit on 32-bit word boundaries; bit 2 picks the word.
  localparam logic REG_WINDOW_LEN = 1'b0;
  localparam logic REG_KNOCK_GAP  = 1'b1;

  logic [WIN_LEN_W-1:0] window_len_r;
  logic [GAP_W-1:0]     knock_gap_r;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= RESET_WINDOW_LEN;
      knock_gap_r  <= RESET_KNOCK_GAP;
    end else if (wr_en) begin
      case (paddr[2])
        REG_WINDOW_LEN: window_len_r <= pwdata[WIN_LEN_W-1:0];
        REG_KNOCK_GAP:  knock_gap_r  <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (paddr[2])
      REG_WINDOW_LEN: prdata = {{(32-WIN_LEN_W){1'b0}}, window_len_r};
      REG_KNOCK_GAP:  prdata = {{(32-GAP_W){1'b0}}, knock_gap_r};
      default:        prdata = '0;
    endcase
  end

  assign cfg.window_len   = window_len_r;
  assign cfg.knock_gap_ms = knock_gap_r;

endmodule

[hw/rtl/dkd_core.sv]
module dkd_core
  import dkd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_WINDOW  = 255
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   fire,
  input  logic                   action,
  input  logic [SAMPLE_BITS-1:0] accel_x,
  input  logic                   sound,
  input  logic [ELAPSED_W-1:0]   elapsed_ms,
  output result_t                res
);

  localparam int CW = $clog2(MAX_WINDOW + 1);   // window count width
  localparam int SW = SAMPLE_BITS + CW;         // calibration sum width
  localparam int DW = SAMPLE_BITS + 2 * CW;     // deviation / threshold width

  typedef enum logic [2:0] {
    PH_CALIB  = 3'b001,
    PH_FIRST  = 3'b010,
    PH_SECOND = 3'b100
  } phase_t;

  phase_t                phase_r, phase_nxt, phase_w;
  logic [CW-1:0]         count_r, count_nxt, count_inc;
  logic signed [SW-1:0]  calib_r, calib_nxt, calib_add;
  logic signed [SW-1:0]  base_r, base_nxt;
  logic [DW-1:0]         dev_r, dev_nxt, dev_add;
  logic                  snd_r, snd_nxt, snd_w;
  logic [GAP_W-1:0]      since_r, since_nxt, since_w;
  logic                  wit_r, wit_nxt, wit_w;

  logic [CW-1:0]         len;
  logic signed [SW:0]    len_x;
  logic signed [SW+1:0]  diff;
  logic [SW:0]           diff_abs;
  logic [SW-1:0]         base_abs;
  logic [DW-1:0]         thresh;
  logic [GAP_W:0]        since_sum;
  logic                  close_win, vib;

  // Effective window length, held to 1..MAX_WINDOW.
  always_comb begin
    if (cfg.window_len == '0) begin
      len = CW'(1);
    end else if (cfg.window_len > WIN_LEN_W'(MAX_WINDOW)) begin
      len = CW'(MAX_WINDOW);
    end else begin
      len = cfg.window_len[CW-1:0];
    end
  end

  // Deviation of this sample from the baseline, scaled by the window length.
  assign len_x     = $signed({1'b0, len}) * $signed(accel_x);
  assign diff      = (SW+2)'(base_r) - (SW+2)'(len_x);
  assign diff_abs  = diff[SW+1] ? (SW+1)'(-diff) : diff[SW:0];

  // Threshold is the baseline magnitude times the window length.
  assign base_abs  = base_r[SW-1] ? SW'(-base_r) : SW'(base_r);
  assign thresh    = DW'(base_abs) * DW'(len);

  assign count_inc = count_r + CW'(1);
  assign calib_add = calib_r + SW'($signed(accel_x));
  assign dev_add   = dev_r + DW'(diff_abs);
  assign since_sum = {1'b0, since_r} + (GAP_W+1)'(elapsed_ms);
  assign close_win = (count_inc >= len);

  // Next state and result for one word.
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    calib_nxt = calib_r;
    base_nxt  = base_r;
    dev_nxt   = dev_r;
    snd_nxt   = snd_r;
    since_nxt = since_r;
    wit_nxt   = wit_r;
    phase_w   = phase_r;
    since_w   = since_r;
    wit_w     = wit_r;
    snd_w     = snd_r | sound;
    vib       = 1'b0;
    res       = '0;

    if (fire) begin
      if (action) begin
        // Recalibrate: everything back to the reset state.
        phase_nxt = PH_CALIB;
        count_nxt = '0;
        calib_nxt = '0;
        base_nxt  = '0;
        dev_nxt   = '0;
        snd_nxt   = 1'b0;
        since_nxt = '0;
        wit_nxt   = 1'b0;
      end else if (phase_r == PH_CALIB) begin
        // Baseline window.
        if (close_win) begin
          base_nxt  = calib_add;
          calib_nxt = '0;
          count_nxt = '0;
          dev_nxt   = '0;
          snd_nxt   = 1'b0;
          phase_nxt = PH_FIRST;
        end else begin
          calib_nxt = calib_add;
          count_nxt = count_inc;
        end
        res.calibrated = close_win;
      end else begin
        // Time only runs while waiting for the second knock.
        if (phase_r == PH_SECOND) begin
          since_w = since_sum[GAP_W] ? {GAP_W{1'b1}} : since_sum[GAP_W-1:0];
        end
        // A new window decides whether it starts inside the gap.
        if (count_r == '0) begin
          if (phase_r == PH_SECOND) begin
            wit_w = (since_w < cfg.knock_gap_ms);
            if (!wit_w) begin
              phase_w = PH_FIRST;
            end
          end else begin
            wit_w = 1'b0;
          end
        end
        if (close_win) begin
          vib = (dev_add > thresh) && snd_w;
          if (phase_w == PH_FIRST) begin
            if (vib) begin
              phase_w = PH_SECOND;
              since_w = '0;
            end
          end else if (vib && wit_w) begin
            res.knock = 1'b1;
            phase_w   = PH_FIRST;
          end
          count_nxt = '0;
          dev_nxt   = '0;
          snd_nxt   = 1'b0;
        end else begin
          count_nxt = count_inc;
          dev_nxt   = dev_add;
          snd_nxt   = snd_w;
        end
        phase_nxt       = phase_w;
        since_nxt       = since_w;
        wit_nxt         = wit_w;
        res.calibrated  = 1'b1;
        res.window_done = close_win;
        res.vibration   = vib;
      end
    end
  end

  // Detector state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CALIB;
      count_r <= '0;
      calib_r <= '0;
      base_r  <= '0;
      dev_r   <= '0;
      snd_r   <= 1'b0;
      since_r <= '0;
      wit_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      calib_r <= calib_nxt;
      base_r  <= base_nxt;
      dev_r   <= dev_nxt;
      snd_r   <= snd_nxt;
      since_r <= since_nxt;
      wit_r   <= wit_nxt;
    end
  end

endmodule

[hw/rtl/double_knock_detector_top.sv]
// Double-knock detector. Each input word carries one signed x-axis sample, the
// sound pin level and the milliseconds since the previous word; every word
// yields exactly one result word, which passes from the input register to the
// result register on the output, and a new word is taken every cycle while the
// output side keeps up. The rate is set by the
// combinational update of the window sums (one length-by-sample multiply, an
// absolute difference, an accumulate and a threshold compare) between the
// input register and the result register. The first window after reset or a
// recalibrate word forms the baseline; later windows report vibration and,
// for a second vibration window that starts inside the gap, a knock.
// window_len sits at address 0 and knock_gap_ms at address 4; change them
// only while no word is in flight.
`include "double_knock_detector_top_assert.svh"

module double_knock_detector_top
  import dkd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_WINDOW  = 255
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input word channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_action,
  input  logic [SAMPLE_BITS-1:0] in_accel_x,
  input  logic                   in_sound,
  input  logic [ELAPSED_W-1:0]   in_elapsed_ms,
  // Result word channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_calibrated,
  output logic                   out_window_done,
  output logic                   out_vibration,
  output logic                   out_knock,
  // Configuration port.
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t                   cfg;
  result_t                res, res_r;
  logic                   in_accept, s0_move;
  logic                   s0_valid_r, s0_valid_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   s0_action_r, s0_sound_r;
  logic [SAMPLE_BITS-1:0] s0_x_r;
  logic [ELAPSED_W-1:0]   s0_el_r;

  dkd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the input register empties whenever the result register can load.
  assign s0_move   = s0_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s0_valid_r && !s0_move;
  assign in_accept = in_valid && !in_stall;

  assign s0_valid_nxt  = in_accept || (s0_valid_r && !s0_move);
  assign out_valid_nxt = s0_move || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input word register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s0_action_r <= in_action;
      s0_x_r      <= in_accel_x;
      s0_sound_r  <= in_sound;
      s0_el_r     <= in_elapsed_ms;
    end
  end

  dkd_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_WINDOW  (MAX_WINDOW)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .fire       (s0_move),
    .action     (s0_action_r),
    .accel_x    (s0_x_r),
    .sound      (s0_sound_r),
    .elapsed_ms (s0_el_r),
    .res        (res)
  );

  // Result word register.
  always_ff @(posedge clk) begin
    if (s0_move) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_calibrated  = res_r.calibrated;
  assign out_window_done = res_r.window_done;
  assign out_vibration   = res_r.vibration;
  assign out_knock       = res_r.knock;

  // Only a closed window can report vibration or a knock.
  `DKD_ASSERT_SAME(a_vib_needs_window, out_valid && !out_window_done, !out_vibration && !out_knock)
  // A knock is always a calibrated vibration window.
  `DKD_ASSERT_SAME(a_knock_is_vib, out_valid && out_knock, out_vibration && out_calibrated)
  // A word that leaves the input register always shows up as a result.
  `DKD_ASSERT_NEXT(a_move_gives_result, s0_move, out_valid)
  // The input side stalls only when the input register is full.
  `DKD_ASSERT_SAME(a_stall_only_full, in_stall, s0_valid_r && out_valid_r)

endmodule

[sim/double_knock_detector_top_test.sv]
module double_knock_detector_top_test;
  import dkd_pkg::*;

  // Register addresses on the configuration port.
  localparam logic [2:0] REG_WINDOW_LEN = 3'd0;
  localparam logic [2:0] REG_KNOCK_GAP  = 3'd4;

  // Codes of the action field.
  localparam logic ACT_SAMPLE      = 1'b0;
  localparam logic ACT_RECALIBRATE = 1'b1;

  localparam int WORD_TARGET  = 1650;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 6;

  typedef enum logic [1:0] {
    CALIBRATING,
    FIRST_KNOCK,
    SECOND_KNOCK
  } listen_phase_t;

  // Tracks the detector state and holds the result words still to come.
  class knock_scoreboard;
    logic [7:0]            window_len;
    logic [15:0]           knock_gap_ms;
    listen_phase_t         phase;
    int unsigned           count;
    longint                calib_sum;
    longint                baseline_sum;
    longint unsigned       deviation_sum;
    bit                    sound_seen;
    int unsigned           since_first_ms;
    bit                    window_in_time;
    result_t               expected_results[$];
    int                    errors;

    function new();
      window_len   = RESET_WINDOW_LEN;
      knock_gap_ms = RESET_KNOCK_GAP;
      errors       = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase          = CALIBRATING;
      count          = 0;
      calib_sum      = 0;
      baseline_sum   = 0;
      deviation_sum  = 0;
      sound_seen     = 0;
      since_first_ms = 0;
      window_in_time = 0;
    endfunction

    function void set_register(logic [2:0] addr, logic [31:0] data);
      if (addr == REG_WINDOW_LEN) begin
        window_len = data[7:0];
      end else if (addr == REG_KNOCK_GAP) begin
        knock_gap_ms = data[15:0];
      end
    endfunction

    // Advances the state by one accepted word and queues the result it causes.
    function void note_word(logic action, logic signed [15:0] accel, logic snd,
                            logic [7:0] elapsed);
      result_t         r;
      longint unsigned len;
      longint          diff;
      longint unsigned mag;
      bit              vib;
      len = (window_len == 0) ? 1 : window_len;
      r = '0;
      if (action == ACT_RECALIBRATE) begin
        clear_state();
        expected_results.push_back(r);
        return;
      end
      if (phase == CALIBRATING) begin
        calib_sum += accel;
        count++;
        if (count >= len) begin
          baseline_sum  = calib_sum;
          calib_sum     = 0;
          count         = 0;
          deviation_sum = 0;
          sound_seen    = 0;
          phase         = FIRST_KNOCK;
        end
      end else begin
        // Time only runs while a second knock is awaited.
        if (phase == SECOND_KNOCK) begin
          since_first_ms += elapsed;
          if (since_first_ms > 65535) since_first_ms = 65535;
        end
        // The gap is judged at the first sample of a window.
        if (count == 0) begin
          if (phase == SECOND_KNOCK) begin
            window_in_time = (since_first_ms < knock_gap_ms);
            if (!window_in_time) phase = FIRST_KNOCK;
          end else begin
            window_in_time = 0;
          end
        end
        diff = baseline_sum - longint'(len) * accel;
        deviation_sum += unsigned'((diff < 0) ? -diff : diff);
        if (snd) sound_seen = 1;
        count++;
        if (count >= len) begin
          mag = unsigned'((baseline_sum < 0) ? -baseline_sum : baseline_sum);
          vib = (deviation_sum > len * mag) && sound_seen;
          r.window_done = 1'b1;
          r.vibration   = vib;
          if (phase == FIRST_KNOCK) begin
            if (vib) begin
              phase          = SECOND_KNOCK;
              since_first_ms = 0;
            end
          end else if (vib && window_in_time) begin
            r.knock = 1'b1;
            phase   = FIRST_KNOCK;
          end
          count         = 0;
          deviation_sum = 0;
          sound_seen    = 0;
        end
      end
      r.calibrated = (phase != CALIBRATING);
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic want, logic got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Compares one result word with the oldest expectation.
    function void check_result(result_t seen);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result word with none expected: %b", seen);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("calibrated", want.calibrated, seen.calibrated);
      compare_field("window_done", want.window_done, seen.window_done);
      compare_field("vibration", want.vibration, seen.vibration);
      compare_field("knock", want.knock, seen.knock);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [15:0] in_accel_x = '0;
  logic        in_sound = 1'b0;
  logic [7:0]  in_elapsed_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_calibrated;
  logic        out_window_done;
  logic        out_vibration;
  logic        out_knock;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  knock_scoreboard sb;
  int words_sent = 0;
  int burst_left = 0;
  int elapsed_mode = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_period = 2;
  int stall_duty = 1;
  int stall_tick = 0;
  int idle_cycles = 0;

  double_knock_detector_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_accel_x     (in_accel_x),
    .in_sound       (in_sound),
    .in_elapsed_ms  (in_elapsed_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_calibrated (out_calibrated),
    .out_window_done(out_window_done),
    .out_vibration  (out_vibration),
    .out_knock      (out_knock),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver stalls on a randomly chosen pattern that is redrawn when its run ends.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode   = $urandom_range(0, 3);
        stall_left   = $urandom_range(40, 300);
        stall_period = $urandom_range(2, 7);
        stall_duty   = $urandom_range(1, stall_period - 1);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= ((stall_tick % stall_period) < stall_duty);
        default: out_stall <= ($urandom_range(0, 2) != 0);
      endcase
    end
  end

  // Every accepted result word is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result({out_calibrated, out_window_done, out_vibration, out_knock});
    end
  end

  // The run ends when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("double_knock_detector_top_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Bursts of random length separated by random gaps, with some gapless stretches.
  function automatic int next_gap();
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 4) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    return gap;
  endfunction

  function automatic logic [7:0] pick_elapsed();
    case (elapsed_mode)
      0: return 8'($urandom_range(0, 20));
      1: return 8'($urandom_range(0, 255));
      2: return 8'($urandom_range(200, 255));
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [15:0] clamp_sample(int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  function automatic int rand_span(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Offers one word after a gap of idle cycles and waits until it is taken.
  task automatic send_word(int gap, logic action, logic [15:0] accel, logic snd,
                           logic [7:0] elapsed);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_action     <= action;
    in_accel_x    <= accel;
    in_sound      <= snd;
    in_elapsed_ms <= elapsed;
    do @(posedge clk); while (in_stall);
    sb.note_word(action, accel, snd, elapsed);
    words_sent++;
  endtask

  task automatic send_sample(logic [15:0] accel, logic snd, logic [7:0] elapsed);
    send_word(next_gap(), ACT_SAMPLE, accel, snd, elapsed);
  endtask

  task automatic send_recalibrate();
    send_word(next_gap(), ACT_RECALIBRATE, 16'($urandom), 1'($urandom),
              8'($urandom));
  endtask

  // Drains the block so that a register may be written.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes a register, then reads it back.
  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    logic [31:0] mask;
    mask = (addr == REG_WINDOW_LEN) ? 32'h0000_00FF : 32'h0000_FFFF;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(addr, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (data & mask)) begin
      $error("readback at %0d: expected %0h, got %0h", addr, data & mask, prdata & mask);
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One random session: maybe new settings, a calibration window, then
  // detection windows that are loud, quiet or plain noise.
  task automatic run_session();
    int base;
    int amp;
    int len_now;
    int kind;
    int cut;
    logic [15:0] x;
    logic snd;
    if (sb.window_len > 40 || $urandom_range(0, 1) == 1) begin
      settle();
      // A long window left over from before is always replaced.
      if (sb.window_len > 40 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0: cfg_write(REG_WINDOW_LEN, 32'd1);
          1: cfg_write(REG_WINDOW_LEN, 32'd0);
          2: cfg_write(REG_WINDOW_LEN, 32'($urandom_range(20, 40)));
          default: cfg_write(REG_WINDOW_LEN, 32'($urandom_range(2, 12)));
        endcase
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0: cfg_write(REG_KNOCK_GAP, 32'd0);
          1: cfg_write(REG_KNOCK_GAP, 32'd1);
          2: cfg_write(REG_KNOCK_GAP, 32'd65535);
          default: cfg_write(REG_KNOCK_GAP, 32'($urandom_range(50, 3000)));
        endcase
      end
    end
    elapsed_mode = $urandom_range(0, 3);
    base = ($urandom_range(0, 3) == 0) ? 0 : rand_span(-30000, 30000);
    amp  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 200);
    len_now = (sb.window_len == 0) ? 1 : sb.window_len;
    if ($urandom_range(0, 3) != 0) send_recalibrate();
    repeat (len_now) begin
      send_sample(clamp_sample(base + rand_span(-amp, amp)), 1'($urandom),
                  pick_elapsed());
    end
    repeat ($urandom_range(2, 6)) begin
      kind = $urandom_range(0, 9);
      cut  = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len_now - 1) : -1;
      for (int i = 0; i < len_now; i++) begin
        if (i == cut) send_recalibrate();
        case (kind)
          0, 1, 2, 3: begin
            // A loud window; the last kind of these stays silent.
            x = ($urandom_range(0, 1) == 1) ? 16'($urandom)
                : clamp_sample(base + rand_span(-32768, 32767));
            snd = (kind != 3) && ($urandom_range(0, 2) == 0 || i == len_now - 1);
          end
          4, 5, 6: begin
            x   = clamp_sample(base + rand_span(-amp, amp));
            snd = 1'($urandom);
          end
          default: begin
            x   = 16'($urandom);
            snd = 1'($urandom);
          end
        endcase
        if (kind >= 7 && $urandom_range(0, 19) == 0) begin
          send_recalibrate();
        end else begin
          send_sample(x, snd, pick_elapsed());
        end
      end
    end
  endtask

  initial begin
    logic [15:0] extreme;
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single-sample windows: recalibrate with its payload ignored, a zero
    // baseline, a knock in time, silence blocking vibration, an expired wait.
    cfg_write(REG_WINDOW_LEN, 32'd1);
    cfg_write(REG_KNOCK_GAP, 32'd300);
    send_word(0, ACT_RECALIBRATE, 16'h7FFF, 1'b1, 8'd255);
    send_word(0, ACT_SAMPLE, 16'h0000, 1'b0, 8'd0);
    send_word(0, ACT_SAMPLE, 16'h8000, 1'b1, 8'd0);
    send_word(0, ACT_SAMPLE, 16'h7FFF, 1'b1, 8'd255);
    send_word(0, ACT_SAMPLE, 16'h0000, 1'b1, 8'd255);
    send_word(0, ACT_SAMPLE, 16'd5, 1'b0, 8'd17);
    send_word(0, ACT_SAMPLE, 16'd100, 1'b1, 8'd0);
    send_word(1, ACT_SAMPLE, 16'd1, 1'b1, 8'd255);
    send_word(0, ACT_SAMPLE, 16'd1, 1'b1, 8'd0);
    send_word(2, ACT_SAMPLE, 16'd0, 1'b0, 8'd255);
    send_word(0, ACT_SAMPLE, 16'd7, 1'b1, 8'd255);

    // A zero gap never lets a second window count.
    settle();
    cfg_write(REG_KNOCK_GAP, 32'd0);
    send_word(0, ACT_SAMPLE, 16'd9, 1'b1, 8'd3);
    send_word(0, ACT_SAMPLE, -16'sd9, 1'b1, 8'd0);

    // A window length of zero acts as one; the widest gap.
    settle();
    cfg_write(REG_WINDOW_LEN, 32'd0);
    cfg_write(REG_KNOCK_GAP, 32'd65535);
    send_word(0, ACT_RECALIBRATE, 16'h8000, 1'b0, 8'd0);
    send_word(0, ACT_SAMPLE, 16'h8000, 1'b0, 8'd0);
    send_word(0, ACT_SAMPLE, 16'h7FFF, 1'b1, 8'd255);
    send_word(0, ACT_SAMPLE, 16'h8000, 1'b1, 8'd255);

    // Shortening the window mid-way closes it on the next sample.
    settle();
    cfg_write(REG_WINDOW_LEN, 32'd3);
    send_word(0, ACT_RECALIBRATE, 16'h0000, 1'b0, 8'd0);
    repeat (3) send_word(0, ACT_SAMPLE, 16'h8000, 1'b0, 8'd0);
    send_word(0, ACT_SAMPLE, 16'h7FFF, 1'b1, 8'd0);
    settle();
    cfg_write(REG_WINDOW_LEN, 32'd1);
    send_word(0, ACT_SAMPLE, 16'h7FFF, 1'b0, 8'd0);

    // One session at the longest window with samples at the rails.
    settle();
    cfg_write(REG_WINDOW_LEN, 32'd255);
    cfg_write(REG_KNOCK_GAP, 32'd65535);
    elapsed_mode = 1;
    extreme = ($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7FFF;
    send_recalibrate();
    repeat (255) send_sample(extreme, 1'($urandom), pick_elapsed());
    repeat (255) send_sample(~extreme, ($urandom_range(0, 7) == 0), pick_elapsed());

    // Random sessions with mostly short windows.
    while (words_sent < WORD_TARGET) run_session();

    settle();
    if (sb.errors == 0) begin
      $display("double_knock_detector_top_test: done, clean");
    end else begin
      $display("double_knock_detector_top_test: done, errors");
    end
    $finish;
  end

endmodule
